// ----- hw/rtl/pcm_pkg.sv -----
package pcm_pkg;

  localparam int unsigned PCM_PALETTE_DEPTH   = 256;
  localparam int unsigned PCM_VALUE_FRAC_BITS = 16;

  localparam int unsigned VALUE_W    = 48;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 33;

  localparam int unsigned ROOT_IN_W  = 18;
  localparam int unsigned ROOT_STEPS = CHAN_W;

  localparam int unsigned FIFO_DEPTH = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAX_ITERATION   = 3'd0,
    REG_ITERATION_SCALE = 3'd1,
    REG_COLOR_OFFSET    = 3'd2,
    REG_PALETTE_SIZE    = 3'd3,
    REG_GAMMA_ENABLE    = 3'd4
  } cfg_reg_t;

  localparam logic [32:0] MAX_ITERATION_RST   = 33'd1024;
  localparam logic [31:0] ITERATION_SCALE_RST = 32'd16777216;
  localparam logic [15:0] COLOR_OFFSET_RST    = 16'd0;
  localparam logic [8:0]  PALETTE_SIZE_RST    = 9'd1;
  localparam logic        GAMMA_ENABLE_RST    = 1'b0;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

endpackage

// ----- hw/rtl/pcm_interfaces.sv -----
interface pcm_item_if import pcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [INDEX_W-1:0] entry_index;
  logic [CHAN_W-1:0]  entry_red;
  logic [CHAN_W-1:0]  entry_green;
  logic [CHAN_W-1:0]  entry_blue;
  logic [CHAN_W-1:0]  entry_alpha;
  logic [VALUE_W-1:0] iteration_value;

  modport source (
    output valid, mode, entry_index, entry_red, entry_green, entry_blue, entry_alpha,
    output iteration_value,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, entry_red, entry_green, entry_blue, entry_alpha,
    input  iteration_value,
    output ready
  );
endinterface

interface pcm_pixel_if import pcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface pcm_cfg_if import pcm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- hw/rtl/pcm_gamma_root.sv -----
module pcm_gamma_root import pcm_pkg::*; (
  input  logic                 clk,
  input  logic [ROOT_IN_W-1:0] radicand,
  output logic [CHAN_W-1:0]    root
);

  // One result bit per stage: keep the largest n with (2n-1)^2 <= radicand.
  logic [ROOT_IN_W-1:0] rad_q  [ROOT_STEPS];
  logic [CHAN_W-1:0]    part_q [ROOT_STEPS];

  for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
    logic [ROOT_IN_W-1:0] rad_in;
    logic [CHAN_W-1:0]    part_in;
    logic [CHAN_W-1:0]    trial;
    logic [ROOT_IN_W-1:0] odd;
    logic [ROOT_IN_W-1:0] odd_sq;

    if (s == 0) begin : g_first
      assign rad_in  = radicand;
      assign part_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign part_in = part_q[s-1];
    end

    assign trial  = part_in | (CHAN_W'(1) << (CHAN_W - 1 - s));
    assign odd    = {{(ROOT_IN_W-CHAN_W-1){1'b0}}, trial, 1'b0} - ROOT_IN_W'(1);
    assign odd_sq = odd * odd;

    always_ff @(posedge clk) begin
      rad_q[s]  <= rad_in;
      part_q[s] <= (odd_sq <= rad_in) ? trial : part_in;
    end
  end

  assign root = part_q[ROOT_STEPS-1];

endmodule

// ----- hw/rtl/pcm_result_fifo.sv -----
module pcm_result_fifo import pcm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  pixel_t push_data,
  input  logic   pop,
  output pixel_t pop_data,
  output logic   not_empty
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

  pixel_t         slots [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data  = slots[rd_ptr];
  assign not_empty = (fill != '0);

endmodule

// ----- hw/rtl/palette_color_mapper.sv -----
// Palette color mapper: turns a smooth iteration value into one RGBA pixel.
// The items channel carries two kinds of transfer. Mode 0 writes one palette
// entry and gives no pixel; mode 1 maps iteration_value to a pixel, which
// leaves on the pixels channel. Items are handled strictly in order, so a
// palette write is seen by every later pixel item.
// The cfg channel writes the mapping registers and is ready whenever reset
// is low. Write it only while no pixel is in flight; the block itself does
// not enforce this. One item is accepted per cycle while the items channel
// is ready. The path from an accepted item to its pixel runs through two
// partial multipliers, the palette multiply, the palette memory read with
// its registered output, the interpolation multipliers and an eight stage
// square root for gamma.
// Results collect in a 32 entry output queue. The items channel drops ready
// only when the pixels in flight and in the queue would fill it, so a
// stalled receiver holds results without loss and the flow resumes at full
// rate once it takes them again.
// Reset loads the register defaults, empties the pipeline and the queue and
// holds both input channels not ready. The palette memory is not cleared: an
// entry reads as undefined until a mode 0 item writes it.
module palette_color_mapper import pcm_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH   = PCM_PALETTE_DEPTH,
  parameter int unsigned VALUE_FRAC_BITS = PCM_VALUE_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  pcm_cfg_if.sink     cfg,
  pcm_item_if.sink    items,
  pcm_pixel_if.source pixels
);

  localparam int unsigned AddrW   = $clog2(PALETTE_DEPTH);
  localparam int unsigned ProdW   = VALUE_FRAC_BITS + 24;
  localparam int unsigned LimitW  = 33 + VALUE_FRAC_BITS;
  localparam int unsigned CmpW    = (VALUE_W > LimitW) ? VALUE_W : LimitW;
  localparam int unsigned SizeW   = 9;
  localparam int unsigned SizeCap = (PALETTE_DEPTH < 511) ? PALETTE_DEPTH : 511;
  localparam int unsigned MixW    = 24;
  localparam int unsigned PendW   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned WordW   = 4 * CHAN_W;
  localparam int unsigned HalfW   = VALUE_W / 2;

  // Registers.
  logic [32:0]      max_iteration;
  logic [31:0]      iteration_scale;
  logic [15:0]      color_offset;
  logic [SizeW-1:0] palette_size;
  logic             gamma_enable;
  logic [SizeW-1:0] size_eff;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iteration   <= MAX_ITERATION_RST;
      iteration_scale <= ITERATION_SCALE_RST;
      color_offset    <= COLOR_OFFSET_RST;
      palette_size    <= PALETTE_SIZE_RST;
      gamma_enable    <= GAMMA_ENABLE_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.addr))
        REG_MAX_ITERATION:   max_iteration   <= cfg.data;
        REG_ITERATION_SCALE: iteration_scale <= cfg.data[31:0];
        REG_COLOR_OFFSET:    color_offset    <= cfg.data[15:0];
        REG_PALETTE_SIZE:    palette_size    <= cfg.data[SizeW-1:0];
        REG_GAMMA_ENABLE:    gamma_enable    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (palette_size == '0) begin
      size_eff = SizeW'(1);
    end else if (palette_size > SizeW'(SizeCap)) begin
      size_eff = SizeW'(SizeCap);
    end else begin
      size_eff = palette_size;
    end
  end

  // Flow control against the output queue.
  logic             take_pixel;
  logic             give_pixel;
  logic [PendW-1:0] pending;

  assign items.ready = !rst && (pending < PendW'(FIFO_DEPTH));
  assign take_pixel  = items.valid && items.ready && items.mode;
  assign give_pixel  = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (take_pixel && !give_pixel) begin
      pending <= pending + 1'b1;
    end else if (give_pixel && !take_pixel) begin
      pending <= pending - 1'b1;
    end
  end

  // Palette slot of a write index.
  logic [AddrW-1:0] write_slot [2**INDEX_W];

  for (genvar g = 0; g < 2**INDEX_W; g++) begin : g_slot
    localparam int unsigned Slot = g % PALETTE_DEPTH;
    assign write_slot[g] = AddrW'(Slot);
  end

  // Stage 1: input register.
  logic               s1_valid;
  logic               s1_mode;
  logic [INDEX_W-1:0] s1_index;
  logic [WordW-1:0]   s1_word;
  logic [VALUE_W-1:0] s1_value;

  // Stage 2: partial products and limit test.
  logic                       s2_valid;
  logic                       s2_mode;
  logic [AddrW-1:0]           s2_slot;
  logic [WordW-1:0]           s2_word;
  logic                       s2_black;
  logic [HalfW+31:0]          s2_plo;
  logic [VALUE_FRAC_BITS-1:0] s2_phi;
  logic [HalfW+31:0]          prod_lo;
  logic [HalfW+31:0]          prod_hi;
  logic [CmpW-1:0]            limit_ext;
  logic [CmpW-1:0]            value_ext;

  // Stage 3: phase.
  logic             s3_valid;
  logic             s3_mode;
  logic [AddrW-1:0] s3_slot;
  logic [WordW-1:0] s3_word;
  logic             s3_black;
  logic [31:0]      s3_phase;
  logic [ProdW-1:0] prod_frac;
  logic [31:0]      phase;

  // Stage 4: palette positions and weight.
  logic              s4_valid;
  logic              s4_mode;
  logic [AddrW-1:0]  s4_slot;
  logic [WordW-1:0]  s4_word;
  logic              s4_black;
  logic [AddrW-1:0]  s4_i1;
  logic [AddrW-1:0]  s4_i2;
  logic [15:0]       s4_w;
  logic [31+SizeW:0] pos;
  logic [SizeW-1:0]  pos_i1;
  logic [SizeW-1:0]  pos_i2;

  // Stage 5: palette read.
  logic             s5_valid;
  logic             s5_black;
  logic [15:0]      s5_w;
  logic [WordW-1:0] rd_first;
  logic [WordW-1:0] rd_second;
  logic [16:0]      weight_inv;
  logic [WordW-1:0] palette_mem [PALETTE_DEPTH];

  // Stage 6: interpolated channels.
  logic            s6_valid;
  logic            s6_black;
  logic [MixW-1:0] s6_mix [4];

  // Stage 7: rounding and gamma radicands.
  logic                 s7_valid;
  logic                 s7_black;
  pixel_t               s7_plain;
  logic [ROOT_IN_W-1:0] s7_root_in [3];
  logic [CHAN_W-1:0]    plain_ch [4];

  assign prod_lo   = s1_value[HalfW-1:0] * iteration_scale;
  assign prod_hi   = s1_value[VALUE_W-1:HalfW] * iteration_scale;
  assign value_ext = CmpW'(s1_value);
  assign limit_ext = CmpW'({max_iteration, {VALUE_FRAC_BITS{1'b0}}});

  assign prod_frac = ProdW'(s2_plo) + {s2_phi, {HalfW{1'b0}}};
  assign phase     = prod_frac[ProdW-1 -: 32] + {color_offset, 16'h0000};

  assign pos    = s3_phase * size_eff;
  assign pos_i1 = pos[31+SizeW:32];
  assign pos_i2 = ((pos_i1 + 1'b1) == size_eff) ? '0 : pos_i1 + 1'b1;

  assign weight_inv = 17'h10000 - {1'b0, s5_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else begin
      s1_valid <= items.valid && items.ready;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid && s4_mode;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode  <= items.mode;
    s1_index <= items.entry_index;
    s1_word  <= {items.entry_red, items.entry_green, items.entry_blue, items.entry_alpha};
    s1_value <= items.iteration_value;

    s2_mode  <= s1_mode;
    s2_slot  <= write_slot[s1_index];
    s2_word  <= s1_word;
    s2_black <= (value_ext >= limit_ext);
    s2_plo   <= prod_lo;
    s2_phi   <= prod_hi[VALUE_FRAC_BITS-1:0];

    s3_mode  <= s2_mode;
    s3_slot  <= s2_slot;
    s3_word  <= s2_word;
    s3_black <= s2_black;
    s3_phase <= phase;

    s4_mode  <= s3_mode;
    s4_slot  <= s3_slot;
    s4_word  <= s3_word;
    s4_black <= s3_black;
    s4_i1    <= AddrW'(pos_i1);
    s4_i2    <= AddrW'(pos_i2);
    s4_w     <= pos[31:16];

    s5_black <= s4_black;
    s5_w     <= s4_w;

    s6_black <= s5_black;

    s7_black <= s6_black;
    s7_plain <= {plain_ch[0], plain_ch[1], plain_ch[2], plain_ch[3]};
  end

  // Writes and reads meet at one stage, so a write is visible to the next item.
  always_ff @(posedge clk) begin
    if (s4_valid && !s4_mode) begin
      palette_mem[s4_slot] <= s4_word;
    end
    rd_first  <= palette_mem[s4_i1];
    rd_second <= palette_mem[s4_i2];
  end

  for (genvar ch = 0; ch < 4; ch++) begin : g_chan
    logic [MixW:0]   mix_sum;
    logic [MixW+9:0] scaled;
    logic [MixW:0]   rounded;

    assign mix_sum = rd_first[WordW-1-CHAN_W*ch -: CHAN_W] * weight_inv
                   + rd_second[WordW-1-CHAN_W*ch -: CHAN_W] * s5_w;
    assign scaled  = {s6_mix[ch], 10'b0} - {8'b0, s6_mix[ch], 2'b0};
    assign rounded = {1'b0, s6_mix[ch]} + (MixW+1)'(32768);
    assign plain_ch[ch] = rounded[MixW-1 -: CHAN_W];

    always_ff @(posedge clk) begin
      s6_mix[ch] <= mix_sum[MixW-1:0];
    end

    if (ch < 3) begin : g_root_in
      always_ff @(posedge clk) begin
        s7_root_in[ch] <= scaled[MixW+9 -: ROOT_IN_W];
      end
    end
  end

  // Gamma roots, with the other results delayed alongside.
  logic [CHAN_W-1:0]     root_ch [3];
  logic [ROOT_STEPS-1:0] side_valid;
  logic                  side_black [ROOT_STEPS];
  pixel_t                side_plain [ROOT_STEPS];
  pixel_t                result;

  for (genvar ch = 0; ch < 3; ch++) begin : g_root
    pcm_gamma_root u_root (
      .clk      (clk),
      .radicand (s7_root_in[ch]),
      .root     (root_ch[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid <= '0;
    end else begin
      side_valid <= {side_valid[ROOT_STEPS-2:0], s7_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_black[0] <= s7_black;
    side_plain[0] <= s7_plain;
    for (int k = 1; k < ROOT_STEPS; k++) begin
      side_black[k] <= side_black[k-1];
      side_plain[k] <= side_plain[k-1];
    end
  end

  always_comb begin
    if (side_black[ROOT_STEPS-1]) begin
      result = '{red: '0, green: '0, blue: '0, alpha: '1};
    end else if (gamma_enable) begin
      result = '{red: root_ch[0], green: root_ch[1], blue: root_ch[2],
                 alpha: side_plain[ROOT_STEPS-1].alpha};
    end else begin
      result = side_plain[ROOT_STEPS-1];
    end
  end

  pixel_t queue_head;

  pcm_result_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (side_valid[ROOT_STEPS-1]),
    .push_data (result),
    .pop       (give_pixel),
    .pop_data  (queue_head),
    .not_empty (pixels.valid)
  );

  assign pixels.red   = queue_head.red;
  assign pixels.green = queue_head.green;
  assign pixels.blue  = queue_head.blue;
  assign pixels.alpha = queue_head.alpha;

endmodule

// ----- test/palette_color_mapper_tb.sv -----
`timescale 1ns / 100ps

module palette_color_mapper_tb import pcm_pkg::*; ();

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned IDLE_PCT      = 27;
  localparam int unsigned RANDOM_ITEMS  = 1150;
  localparam int unsigned PHASES        = 8;
  localparam logic        MODE_ENTRY    = 1'b0;
  localparam logic        MODE_PIXEL    = 1'b1;

  class palette_mapping;
    logic [32:0] max_iteration   = MAX_ITERATION_RST;
    logic [31:0] iteration_scale = ITERATION_SCALE_RST;
    logic [15:0] color_offset    = COLOR_OFFSET_RST;
    logic [8:0]  palette_size    = PALETTE_SIZE_RST;
    logic        gamma_enable    = GAMMA_ENABLE_RST;
    logic [31:0] palette [PCM_PALETTE_DEPTH];
    bit          written [PCM_PALETTE_DEPTH];
    pixel_t      pending_pixels [$];
    int unsigned wrong_pixels;

    function void set_register(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
      case (sel)
        REG_MAX_ITERATION:   max_iteration   = value[32:0];
        REG_ITERATION_SCALE: iteration_scale = value[31:0];
        REG_COLOR_OFFSET:    color_offset    = value[15:0];
        REG_PALETTE_SIZE:    palette_size    = value[8:0];
        REG_GAMMA_ENABLE:    gamma_enable    = value[0];
        default: ;
      endcase
    endfunction

    function logic [48:0] black_limit();
      return 49'(max_iteration) << PCM_VALUE_FRAC_BITS;
    endfunction

    function int unsigned used_entries();
      if (palette_size == 0) return 1;
      if (palette_size > PCM_PALETTE_DEPTH) return PCM_PALETTE_DEPTH;
      return 32'(palette_size);
    endfunction

    function void locate(input logic [47:0] v, output int unsigned lo,
                         output int unsigned hi, output logic [15:0] w);
      logic [79:0] prod;
      logic [31:0] phase;
      logic [40:0] pos;
      int unsigned n;
      n = used_entries();
      prod = {32'b0, v} * {48'b0, iteration_scale};
      phase = prod[PCM_VALUE_FRAC_BITS+23:PCM_VALUE_FRAC_BITS-8];
      phase = phase + {color_offset, 16'b0};
      pos = 41'(phase) * 41'(n);
      lo = 32'(pos[40:32]);
      if (lo >= n) lo = n - 1;
      hi = (lo + 1 == n) ? 0 : lo + 1;
      w = pos[31:16];
    endfunction

    function logic [7:0] gamma_round(logic [31:0] c);
      longint unsigned t;
      longint unsigned odd;
      logic [7:0] n;
      int k;
      t = 64'd1020 * c;
      n = 8'd0;
      for (k = 1; k <= 255; k++) begin
        odd = 64'(2 * k - 1);
        if (odd * odd * 65536 <= t) n = 8'(k);
      end
      return n;
    endfunction

    function pixel_t map_value(logic [47:0] v);
      int unsigned lo, hi, ch;
      logic [15:0] w;
      logic [31:0] e1, e2, c;
      logic [7:0] chan [4];
      pixel_t p;
      if (49'(v) >= black_limit()) begin
        p.red   = 8'd0;
        p.green = 8'd0;
        p.blue  = 8'd0;
        p.alpha = 8'd255;
        return p;
      end
      locate(v, lo, hi, w);
      e1 = palette[lo];
      e2 = palette[hi];
      for (ch = 0; ch < 4; ch++) begin
        c = 32'(e1[31-8*ch -: 8]) * (32'd65536 - 32'(w)) + 32'(e2[31-8*ch -: 8]) * 32'(w);
        if (ch < 3 && gamma_enable) chan[ch] = gamma_round(c);
        else chan[ch] = 8'((c + 32'd32768) >> 16);
      end
      p.red   = chan[0];
      p.green = chan[1];
      p.blue  = chan[2];
      p.alpha = chan[3];
      return p;
    endfunction

    function void take_item(logic mode, logic [7:0] idx, logic [31:0] rgba, logic [47:0] v);
      if (mode == MODE_ENTRY) begin
        palette[idx % PCM_PALETTE_DEPTH] = rgba;
        written[idx % PCM_PALETTE_DEPTH] = 1'b1;
      end else begin
        pending_pixels.insert(pending_pixels.size(), map_value(v));
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        wrong_pixels++;
        if (wrong_pixels <= 10)
          $display("unexpected pixel r=%0d g=%0d b=%0d a=%0d",
                   got.red, got.green, got.blue, got.alpha);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.alpha !== want.alpha) begin
        wrong_pixels++;
        if (wrong_pixels <= 10)
          $display("pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                   want.red, want.green, want.blue, want.alpha,
                   got.red, got.green, got.blue, got.alpha);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm;
  palette_mapping model;

  pcm_cfg_if   cfg_bus ();
  pcm_item_if  item_bus ();
  pcm_pixel_if pixel_bus ();

  palette_color_mapper uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .items  (item_bus),
    .pixels (pixel_bus)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    pixel_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && pixel_bus.valid && pixel_bus.ready)
      model.check_pixel({pixel_bus.red, pixel_bus.green, pixel_bus.blue, pixel_bus.alpha});
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cfg_bus.valid && cfg_bus.ready) || (item_bus.valid && item_bus.ready) ||
          (pixel_bus.valid && pixel_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("[palette_color_mapper] ERROR");
    $finish;
  end

  task automatic send_item(input logic mode, input logic [7:0] idx, input logic [31:0] rgba,
                           input logic [47:0] v);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    item_bus.valid           <= 1'b1;
    item_bus.mode            <= mode;
    item_bus.entry_index     <= idx;
    item_bus.entry_red       <= rgba[31:24];
    item_bus.entry_green     <= rgba[23:16];
    item_bus.entry_blue      <= rgba[15:8];
    item_bus.entry_alpha     <= rgba[7:0];
    item_bus.iteration_value <= v;
    do @(posedge clk); while (!item_bus.ready);
    model.take_item(mode, idx, rgba, v);
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic [31:0] rgba);
    send_item(MODE_ENTRY, idx, rgba, 48'({$urandom, $urandom}));
  endtask

  // Entries that the pixel would blend are loaded first, so no pixel blends
  // an unwritten palette slot.
  task automatic map_pixel(input logic [47:0] v);
    int unsigned lo, hi;
    logic [15:0] w;
    model.locate(v, lo, hi, w);
    if (!model.written[lo]) write_entry(8'(lo), $urandom);
    if (!model.written[hi]) write_entry(8'(hi), $urandom);
    send_item(MODE_PIXEL, 8'($urandom), $urandom, v);
  endtask

  task automatic settle();
    item_bus.valid <= 1'b0;
    while (model.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= sel;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    model.set_register(sel, value);
    @(posedge clk);
  endtask

  task automatic configure(input logic [32:0] max_it, input logic [31:0] scale,
                           input logic [15:0] offset, input logic [8:0] size,
                           input logic gamma);
    settle();
    write_register(REG_MAX_ITERATION, max_it);
    write_register(REG_ITERATION_SCALE, 33'(scale));
    write_register(REG_COLOR_OFFSET, 33'(offset));
    write_register(REG_PALETTE_SIZE, 33'(size));
    write_register(REG_GAMMA_ENABLE, 33'(gamma));
  endtask

  function automatic logic [47:0] pick_value();
    logic [63:0] r;
    logic [48:0] lim, near;
    r = {$urandom, $urandom};
    lim = model.black_limit();
    case ($urandom_range(9))
      0, 1: return r[47:0];
      2: begin
        if (lim == 0) return r[47:0];
        near = lim - 1 + $urandom_range(2);
        return near[48] ? r[47:0] : near[47:0];
      end
      3: return {28'($urandom_range(15)), r[19:0]};
      default: return (lim == 0) ? r[47:0] : 48'(r % lim);
    endcase
  endfunction

  initial begin
    int unsigned ph, n;
    model = new();
    rst                      <= 1'b1;
    cfg_bus.valid            <= 1'b0;
    cfg_bus.addr             <= REG_MAX_ITERATION;
    cfg_bus.data             <= '0;
    item_bus.valid           <= 1'b0;
    item_bus.mode            <= MODE_ENTRY;
    item_bus.entry_index     <= '0;
    item_bus.entry_red       <= '0;
    item_bus.entry_green     <= '0;
    item_bus.entry_blue      <= '0;
    item_bus.entry_alpha     <= '0;
    item_bus.iteration_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_entry(8'd0, 32'hFF00FF00);
    write_entry(8'd255, 32'h00FF00FF);
    map_pixel(48'h0);
    map_pixel(48'h0000_0000_8000);
    map_pixel({32'd1023, 16'hFFFF});
    map_pixel({32'd1024, 16'h0000});
    map_pixel(48'hFFFF_FFFF_FFFF);

    configure(33'h1_0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 9'd2, 1'b1);
    write_entry(8'd1, 32'hFFFFFFFF);
    map_pixel(48'h0);
    map_pixel(48'hFFFF_FFFF_FFFF);
    map_pixel(48'h0000_0001_0000);
    map_pixel(48'h0000_0000_0001);

    configure(33'd1, 32'd0, 16'h8000, 9'd511, 1'b0);
    map_pixel(48'h0000_0000_FFFF);
    map_pixel(48'h0000_0001_0000);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(33'h1_0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 9'd256, 1'b1);
        1: configure(33'd0, $urandom, 16'd0, 9'd0, 1'b0);
        2: configure({1'($urandom_range(1)), 32'($urandom)}, $urandom,
                     16'($urandom_range(65535)), 9'd511, 1'b1);
        3: configure(33'(MAX_ITERATION_RST), ITERATION_SCALE_RST, 16'd0, 9'd1, 1'b0);
        4: configure(33'($urandom_range(4096)), 32'd0, 16'($urandom_range(65535)),
                     9'($urandom_range(256, 1)), 1'b0);
        default: configure(($urandom_range(1) != 0) ? 33'($urandom_range(4096))
                                                    : {1'($urandom_range(1)), 32'($urandom)},
                           $urandom, 16'($urandom_range(65535)),
                           9'($urandom_range(511)), 1'($urandom_range(1)));
      endcase
      calm = (ph == 2);
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if ($urandom_range(99) < 25) write_entry(8'($urandom_range(255)), $urandom);
        else map_pixel(pick_value());
      end
    end
    calm = 1'b0;

    settle();
    if (model.wrong_pixels == 0 && model.pending_pixels.size() == 0) begin
      $display("[palette_color_mapper] OK");
    end else begin
      $display("[palette_color_mapper] ERROR");
    end
    $finish;
  end

endmodule
